// ===== src/dts_pkg.sv =====
// Shared types and constants of the dispense trigger spacing block.
// No dependencies; every other file imports this package.
package dts_pkg;

  localparam int unsigned UM_W    = 24;  // micrometre fields
  localparam int unsigned MS_W    = 16;  // millisecond fields
  localparam int unsigned MIN_W   = 18;  // sum of three millisecond terms
  localparam int unsigned MPL_W   = 18;  // serial multiplier, multiplier operand
  localparam int unsigned PROD_W  = 42;  // UM_W + MPL_W
  localparam int unsigned DEN_W   = 25;  // twice a speed
  localparam int unsigned WRAP_W  = 25;  // residual plus length
  localparam int unsigned DSTEP_W = 6;
  localparam int unsigned MSTEP_W = 5;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned STAT_W  = 2;

  localparam logic [MSTEP_W-1:0] MUL_STEPS    = 5'd18;
  localparam logic [DSTEP_W-1:0] DIV_STEPS    = 6'd42;
  localparam logic [DSTEP_W-1:0] DIV_STEPS_WR = 6'd25;
  localparam int unsigned        WRAP_PAD     = PROD_W - WRAP_W;

  localparam logic [PROD_W-1:0] ROUND_HALF   = 42'd500;
  localparam logic [DEN_W-1:0]  MS_PER_S     = 25'd1000;
  localparam logic [MPL_W-1:0]  TWO_MS_PER_S = 18'd2000;

  // Register indexes (byte address = 4 * index)
  localparam logic [IDX_W-1:0] REG_SPATIAL   = 3'd0;
  localparam logic [IDX_W-1:0] REG_TIME      = 3'd1;
  localparam logic [IDX_W-1:0] REG_PULSE     = 3'd2;
  localparam logic [IDX_W-1:0] REG_RESPONSE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MARGIN    = 3'd4;
  localparam logic [IDX_W-1:0] REG_FLOOR     = 3'd5;
  localparam logic [IDX_W-1:0] REG_DOWNGRADE = 3'd6;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_PLANNED   = 2'd0;
  localparam logic [STAT_W-1:0] ST_SKIPPED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_VIOLATION = 2'd2;

  typedef struct packed {
    logic [UM_W-1:0] spatial_um;
    logic [MS_W-1:0] time_ms;
    logic [MS_W-1:0] pulse_ms;
    logic [MS_W-1:0] response_ms;
    logic [MS_W-1:0] extra_ms;
    logic [MS_W-1:0] floor_ms;
    logic            downgrade_en;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [UM_W-1:0]   mcand;
    logic [MPL_W-1:0]  mplier;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [PROD_W-1:0]  num;
    logic [DEN_W-1:0]   den;
    logic [DSTEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quot;
    logic [DEN_W-1:0]  rem;
  } div_rsp_t;

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_CHECK      = 13'b0000000000010,
    S_MUL_TIME   = 13'b0000000000100,
    S_DIV_TIME   = 13'b0000000001000,
    S_MUL_PERIOD = 13'b0000000010000,
    S_DIV_PERIOD = 13'b0000000100000,
    S_SAFETY     = 13'b0000001000000,
    S_MUL_DOWN   = 13'b0000010000000,
    S_DIV_DOWN   = 13'b0000100000000,
    S_PLACE      = 13'b0001000000000,
    S_DIV_WRAP   = 13'b0010000000000,
    S_DIV_COUNT  = 13'b0100000000000,
    S_DONE       = 13'b1000000000000
  } state_e;

endpackage

// ===== src/dts_intf.sv =====
// Handshake interfaces for the segment and result channels.
// Depends on dts_pkg for the field widths.
interface dts_seg_if import dts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [UM_W-1:0] segment_length_um;
  logic [UM_W-1:0] speed_um_per_s;

  modport source (output valid, segment_length_um, speed_um_per_s, input ready);
  modport sink   (input valid, segment_length_um, speed_um_per_s, output ready);
endinterface

interface dts_res_if import dts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [UM_W-1:0]   spacing_um;
  logic [MS_W-1:0]   period_ms;
  logic              downgraded;
  logic [UM_W-1:0]   first_distance_um;
  logic [MS_W-1:0]   trigger_count;
  logic [UM_W-1:0]   residual_um;

  modport source (output valid, status, spacing_um, period_ms, downgraded,
                  first_distance_um, trigger_count, residual_um, input ready);
  modport sink   (input valid, status, spacing_um, period_ms, downgraded,
                  first_distance_um, trigger_count, residual_um, output ready);
endinterface

// ===== src/dts_cfg.sv =====
// APB-style register file holding the seven configuration registers.
// Depends on dts_pkg for cfg_t and the register indexes.
module dts_cfg import dts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t             cfg_q, cfg_d;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_SPATIAL:   cfg_d.spatial_um   = pwdata[UM_W-1:0];
        REG_TIME:      cfg_d.time_ms      = pwdata[MS_W-1:0];
        REG_PULSE:     cfg_d.pulse_ms     = pwdata[MS_W-1:0];
        REG_RESPONSE:  cfg_d.response_ms  = pwdata[MS_W-1:0];
        REG_MARGIN:    cfg_d.extra_ms     = pwdata[MS_W-1:0];
        REG_FLOOR:     cfg_d.floor_ms     = pwdata[MS_W-1:0];
        REG_DOWNGRADE: cfg_d.downgrade_en = pwdata[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPATIAL:   prdata = DATA_W'(cfg_q.spatial_um);
      REG_TIME:      prdata = DATA_W'(cfg_q.time_ms);
      REG_PULSE:     prdata = DATA_W'(cfg_q.pulse_ms);
      REG_RESPONSE:  prdata = DATA_W'(cfg_q.response_ms);
      REG_MARGIN:    prdata = DATA_W'(cfg_q.extra_ms);
      REG_FLOOR:     prdata = DATA_W'(cfg_q.floor_ms);
      REG_DOWNGRADE: prdata = DATA_W'(cfg_q.downgrade_en);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q              <= '0;
      cfg_q.downgrade_en <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/dts_mul.sv =====
// Serial shift-add multiplier, one multiplier bit per cycle.
// Depends on dts_pkg for mul_req_t and mul_rsp_t.
module dts_mul import dts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic               busy_q, busy_d, done_q, done_d;
  logic [MSTEP_W-1:0] cnt_q, cnt_d;
  logic [UM_W-1:0]    hi_q, hi_d, mcand_q, mcand_d;
  logic [MPL_W-1:0]   lo_q, lo_d;
  logic [UM_W:0]      sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    mcand_d = mcand_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = MUL_STEPS;
      hi_d    = '0;
      lo_d    = req_i.mplier;
      mcand_d = req_i.mcand;
    end else if (busy_q) begin
      hi_d  = sum[UM_W:1];
      lo_d  = {sum[0], lo_q[MPL_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MSTEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    mcand_q <= mcand_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = {hi_q, lo_q};

endmodule

// ===== src/dts_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by every division.
// Depends on dts_pkg for div_req_t and div_rsp_t.
module dts_div import dts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d, done_q, done_d;
  logic [DSTEP_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]   rem_q, rem_d, den_q, den_d;
  logic [DEN_W:0]     trial, diff;
  logic               fits;

  // shift the next numerator bit into the partial remainder
  assign trial = {rem_q, num_q[PROD_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      num_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_d = {num_q[PROD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DSTEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== src/dispense_trigger_spacing_top.sv =====
// Dispense trigger spacing planner: top level with the sequencer.
// Depends on dts_pkg, dts_intf, dts_cfg, dts_mul and dts_div.
//
// Usage: each word on seg_i is one motion segment (length in um, path speed
// in um/s). For each word the block returns exactly one word on res_o with
// the status, resolved spacing and period, the downgrade flag, the first
// trigger distance, the trigger count and the residual carried onwards.
// Registers are written over the APB-style port (byte address 4 * index) and
// must only change while no segment is in flight.
// Path from the accepted segment to res_o.valid: a segment with zero length
// or speed goes straight to the final state; with a fixed spacing and a set
// time interval, two 25-step divides place the triggers. Each derived
// quantity (spacing from the time interval, period from the spacing, or the
// spacing raised to the safety minimum) adds an 18-step serial multiply and
// a 42-step serial divide, with at most two derived quantities per segment.
// All divides run in turn on the single shared bit-serial divider.
// Throughput: one segment at a time; seg_i.ready is high only when idle.
// The result sits in an output register, so the next segment is taken while
// the receiver stalls; that segment then holds in the final state until the
// output register frees up.
// Reset clears the carried residual, all registers (downgrade enable to 1)
// and drops any result word still waiting.
module dispense_trigger_spacing_top import dts_pkg::*; #(
  parameter int unsigned MAX_TRIGGERS = 65535
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dts_seg_if.sink           seg_i,
  dts_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // the count saturates at the smaller of the parameter and the field range
  localparam int unsigned CountLimit = (MAX_TRIGGERS > 65535) ? 65535 : MAX_TRIGGERS;
  localparam logic [MS_W-1:0] CountMax = MS_W'(CountLimit);

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  dts_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dts_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  dts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  state_e            state_q, state_d;
  logic [UM_W-1:0]   len_q, len_d, speed_q, speed_d;
  logic [UM_W-1:0]   spacing_q, spacing_d, first_q, first_d, carry_q, carry_d;
  logic [MS_W-1:0]   period_q, period_d, count_q, count_d;
  logic              down_q, down_d;
  logic [STAT_W-1:0] status_q, status_d;

  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q;
  logic [UM_W-1:0]   out_spacing_q, out_first_q, out_resid_q;
  logic [MS_W-1:0]   out_period_q, out_count_q;
  logic              out_down_q;
  logic              res_load;

  logic [MIN_W-1:0]  min_sum, min_ms;
  logic [UM_W-1:0]   quot_sat_um, wrap_carry;
  logic [MS_W-1:0]   quot_sat_ms, min_sat_ms, count_sat;
  logic [WRAP_W-1:0] wrap_sum;
  logic              planned;

  // valve safety minimum, raised to the floor when that is larger
  assign min_sum = MIN_W'(cfg.pulse_ms) + MIN_W'(cfg.response_ms) + MIN_W'(cfg.extra_ms);
  assign min_ms  = (MIN_W'(cfg.floor_ms) > min_sum) ? MIN_W'(cfg.floor_ms) : min_sum;
  assign min_sat_ms = (|min_ms[MIN_W-1:MS_W]) ? '1 : min_ms[MS_W-1:0];

  assign quot_sat_um = (|div_rsp.quot[PROD_W-1:UM_W]) ? '1 : div_rsp.quot[UM_W-1:0];
  assign quot_sat_ms = (|div_rsp.quot[PROD_W-1:MS_W]) ? '1 : div_rsp.quot[MS_W-1:0];
  assign count_sat   = (div_rsp.quot > PROD_W'(CountMax)) ? CountMax
                                                          : div_rsp.quot[MS_W-1:0];

  // residual folded below the spacing, plus the segment length
  assign wrap_carry = div_rsp.rem[UM_W-1:0];
  assign wrap_sum   = WRAP_W'(wrap_carry) + WRAP_W'(len_q);

  assign seg_i.ready = (state_q == S_IDLE);
  assign res_load    = (state_q == S_DONE) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    speed_d   = speed_q;
    spacing_d = spacing_q;
    period_d  = period_q;
    first_d   = first_q;
    count_d   = count_q;
    carry_d   = carry_q;
    down_d    = down_q;
    status_d  = status_q;

    mul_req        = '0;
    mul_req.mcand  = speed_q;
    mul_req.mplier = MPL_W'(cfg.time_ms);
    div_req        = '0;
    div_req.num    = mul_rsp.prod + ROUND_HALF;
    div_req.den    = MS_PER_S;
    div_req.steps  = DIV_STEPS;

    case (state_q)
      S_IDLE: begin
        if (seg_i.valid) begin
          len_d   = seg_i.segment_length_um;
          speed_d = seg_i.speed_um_per_s;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        down_d   = 1'b0;
        first_d  = '0;
        count_d  = '0;
        status_d = ST_PLANNED;
        period_d = cfg.time_ms;
        if (len_q == '0 || speed_q == '0) begin
          status_d = ST_SKIPPED;
          state_d  = S_DONE;
        end else if (cfg.spatial_um != '0) begin
          spacing_d = cfg.spatial_um;
          if (cfg.time_ms != '0) begin
            state_d = S_SAFETY;
          end else begin
            // derive the period from the fixed spacing
            mul_req.start  = 1'b1;
            mul_req.mcand  = cfg.spatial_um;
            mul_req.mplier = TWO_MS_PER_S;
            state_d        = S_MUL_PERIOD;
          end
        end else if (cfg.time_ms != '0) begin
          mul_req.start = 1'b1;
          state_d       = S_MUL_TIME;
        end else begin
          spacing_d = '0;
          period_d  = MS_W'(1);
          state_d   = S_SAFETY;
        end
      end

      S_MUL_TIME: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          state_d       = S_DIV_TIME;
        end
      end

      S_DIV_TIME: begin
        if (div_rsp.done) begin
          spacing_d = quot_sat_um;
          state_d   = S_SAFETY;
        end
      end

      S_MUL_PERIOD: begin
        if (mul_rsp.done) begin
          // round half up: (2*spacing*1000 + speed) / (2*speed)
          div_req.start = 1'b1;
          div_req.num   = mul_rsp.prod + PROD_W'(speed_q);
          div_req.den   = {speed_q, 1'b0};
          state_d       = S_DIV_PERIOD;
        end
      end

      S_DIV_PERIOD: begin
        if (div_rsp.done) begin
          period_d = (quot_sat_ms == '0) ? MS_W'(1) : quot_sat_ms;
          state_d  = S_SAFETY;
        end
      end

      S_SAFETY: begin
        if (min_ms != '0 && MIN_W'(period_q) < min_ms) begin
          if (!cfg.downgrade_en) begin
            status_d = ST_VIOLATION;
            state_d  = S_DONE;
          end else begin
            period_d       = min_sat_ms;
            down_d         = 1'b1;
            mul_req.start  = 1'b1;
            mul_req.mplier = min_ms;
            state_d        = S_MUL_DOWN;
          end
        end else begin
          state_d = S_PLACE;
        end
      end

      S_MUL_DOWN: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          state_d       = S_DIV_DOWN;
        end
      end

      S_DIV_DOWN: begin
        if (div_rsp.done) begin
          spacing_d = quot_sat_um;
          state_d   = S_PLACE;
        end
      end

      S_PLACE: begin
        if (spacing_q == '0) begin
          // no spacing: no triggers, residual passes through
          state_d = S_DONE;
        end else begin
          // fold the carried residual below the spacing
          div_req.start = 1'b1;
          div_req.num   = {1'b0, carry_q, WRAP_PAD'(0)};
          div_req.den   = DEN_W'(spacing_q);
          div_req.steps = DIV_STEPS_WR;
          state_d       = S_DIV_WRAP;
        end
      end

      S_DIV_WRAP: begin
        if (div_rsp.done) begin
          first_d = spacing_q - wrap_carry;
          // count = (carry + len) / spacing, residual = (carry + len) % spacing
          div_req.start = 1'b1;
          div_req.num   = {wrap_sum, WRAP_PAD'(0)};
          div_req.den   = DEN_W'(spacing_q);
          div_req.steps = DIV_STEPS_WR;
          state_d       = S_DIV_COUNT;
        end
      end

      S_DIV_COUNT: begin
        if (div_rsp.done) begin
          count_d = count_sat;
          carry_d = div_rsp.rem[UM_W-1:0];
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      carry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      carry_q <= carry_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    speed_q   <= speed_d;
    spacing_q <= spacing_d;
    period_q  <= period_d;
    first_q   <= first_d;
    count_q   <= count_d;
    down_q    <= down_d;
    status_q  <= status_d;
  end

  // skipped and violating segments report only their status and the carried residual
  assign planned = (status_q == ST_PLANNED);

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_status_q  <= status_q;
      out_spacing_q <= planned ? spacing_q : '0;
      out_period_q  <= planned ? period_q : '0;
      out_down_q    <= planned && down_q;
      out_first_q   <= planned ? first_q : '0;
      out_count_q   <= planned ? count_q : '0;
      out_resid_q   <= carry_q;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.status            = out_status_q;
  assign res_o.spacing_um        = out_spacing_q;
  assign res_o.period_ms         = out_period_q;
  assign res_o.downgraded        = out_down_q;
  assign res_o.first_distance_um = out_first_q;
  assign res_o.trigger_count     = out_count_q;
  assign res_o.residual_um       = out_resid_q;

endmodule

// ===== bench/dts_plan_checker.sv =====
// Result checker for the dispense trigger spacing block: snoops the register
// port, predicts every result word and compares it with what the block sends.
// Depends on dts_pkg and dts_intf.
`timescale 1ns / 100ps
module dts_plan_checker import dts_pkg::*; #(
  parameter int unsigned MAX_TRIGGERS = 65535
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dts_seg_if                seg_i,
  dts_res_if                res_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int unsigned       pending_o,
  output int unsigned       mismatches_o
);

  localparam bit [63:0]   UM_MAX    = 64'hFF_FFFF;
  localparam bit [63:0]   MS_MAX    = 64'hFFFF;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [UM_W-1:0]   spacing_um;
    logic [MS_W-1:0]   period_ms;
    logic              downgraded;
    logic [UM_W-1:0]   first_distance_um;
    logic [MS_W-1:0]   trigger_count;
    logic [UM_W-1:0]   residual_um;
  } plan_t;

  cfg_t            setting;
  logic [UM_W-1:0] carry_um;
  plan_t           plans_due[$];
  int unsigned     mismatches = 0;

  assign mismatches_o = mismatches;

  // Print only the first few, count them all.
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic bit [63:0] ms_to_um(input bit [63:0] speed, input bit [63:0] ms);
    bit [63:0] um;
    um = (speed * ms + 64'd500) / 64'd1000;
    return (um > UM_MAX) ? UM_MAX : um;
  endfunction

  function automatic plan_t plan_segment(input logic [UM_W-1:0] length_um,
                                         input logic [UM_W-1:0] speed_um);
    bit [63:0] len, speed, spacing, period, minimum, carry, first, count, cap;
    plan_t     p;
    len   = 64'(length_um);
    speed = 64'(speed_um);
    p = '0;
    p.residual_um = carry_um;
    if (len == 0 || speed == 0) begin
      p.status = ST_SKIPPED;
      return p;
    end
    if (setting.spatial_um != '0) spacing = 64'(setting.spatial_um);
    else if (setting.time_ms != '0) spacing = ms_to_um(speed, 64'(setting.time_ms));
    else spacing = 0;

    period = 64'(setting.time_ms);
    if (period == 0 && spacing != 0) begin
      period = (2 * spacing * 1000 + speed) / (2 * speed);
      if (period > MS_MAX) period = MS_MAX;
    end
    if (period == 0) period = 1;

    minimum = 64'(setting.pulse_ms) + 64'(setting.response_ms) + 64'(setting.extra_ms);
    if (64'(setting.floor_ms) > minimum) minimum = 64'(setting.floor_ms);
    if (minimum != 0 && period < minimum) begin
      if (!setting.downgrade_en) begin
        p.status = ST_VIOLATION;
        return p;
      end
      period       = minimum;
      spacing      = ms_to_um(speed, minimum);
      p.downgraded = 1'b1;
    end

    p.status     = ST_PLANNED;
    p.spacing_um = UM_W'(spacing);
    p.period_ms  = MS_W'((period > MS_MAX) ? MS_MAX : period);
    if (spacing != 0) begin
      carry = 64'(carry_um);
      if (carry >= spacing) carry = carry % spacing;
      first = spacing - carry;
      count = (len >= first) ? (len - first) / spacing + 1 : 0;
      cap   = (64'(MAX_TRIGGERS) > MS_MAX) ? MS_MAX : 64'(MAX_TRIGGERS);
      if (count > cap) count = cap;
      p.first_distance_um = UM_W'(first);
      p.trigger_count     = MS_W'(count);
      p.residual_um       = UM_W'((carry + len) % spacing);
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    plan_t             want;
    logic [DATA_W-1:0] held;
    if (!rst_ni) begin
      setting              = '0;
      setting.downgrade_en = 1'b1;
      carry_um             = '0;
      plans_due.delete();
    end else begin
      if (psel && penable && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_SPATIAL:   held = DATA_W'(setting.spatial_um);
          REG_TIME:      held = DATA_W'(setting.time_ms);
          REG_PULSE:     held = DATA_W'(setting.pulse_ms);
          REG_RESPONSE:  held = DATA_W'(setting.response_ms);
          REG_MARGIN:    held = DATA_W'(setting.extra_ms);
          REG_FLOOR:     held = DATA_W'(setting.floor_ms);
          REG_DOWNGRADE: held = DATA_W'(setting.downgrade_en);
          default:       held = '0;
        endcase
        if (!pwrite) begin
          if (prdata !== held)
            report_mismatch($sformatf("readback of register %0d", paddr[ADDR_W-1:2]),
                            prdata, held);
        end else begin
          case (paddr[ADDR_W-1:2])
            REG_SPATIAL:   setting.spatial_um   = pwdata[UM_W-1:0];
            REG_TIME:      setting.time_ms      = pwdata[MS_W-1:0];
            REG_PULSE:     setting.pulse_ms     = pwdata[MS_W-1:0];
            REG_RESPONSE:  setting.response_ms  = pwdata[MS_W-1:0];
            REG_MARGIN:    setting.extra_ms     = pwdata[MS_W-1:0];
            REG_FLOOR:     setting.floor_ms     = pwdata[MS_W-1:0];
            REG_DOWNGRADE: setting.downgrade_en = pwdata[0];
            default: ;
          endcase
        end
      end

      // Compare before predicting: a result word always belongs to an older segment.
      if (res_i.valid && res_i.ready) begin
        if (plans_due.size() == 0) begin
          report_mismatch("result word with none due", 1, 0);
        end else begin
          want = plans_due.pop_front();
          if (res_i.status !== want.status)
            report_mismatch("status", res_i.status, want.status);
          if (res_i.spacing_um !== want.spacing_um)
            report_mismatch("spacing_um", res_i.spacing_um, want.spacing_um);
          if (res_i.period_ms !== want.period_ms)
            report_mismatch("period_ms", res_i.period_ms, want.period_ms);
          if (res_i.downgraded !== want.downgraded)
            report_mismatch("downgraded", res_i.downgraded, want.downgraded);
          if (res_i.first_distance_um !== want.first_distance_um)
            report_mismatch("first_distance_um", res_i.first_distance_um,
                            want.first_distance_um);
          if (res_i.trigger_count !== want.trigger_count)
            report_mismatch("trigger_count", res_i.trigger_count, want.trigger_count);
          if (res_i.residual_um !== want.residual_um)
            report_mismatch("residual_um", res_i.residual_um, want.residual_um);
        end
      end

      if (seg_i.valid && seg_i.ready) begin
        want     = plan_segment(seg_i.segment_length_um, seg_i.speed_um_per_s);
        carry_um = want.residual_um;
        plans_due.insert(plans_due.size(), want);
      end
    end
    pending_o <= plans_due.size();
  end

endmodule

// ===== bench/dispense_trigger_spacing_top_test.sv =====
// Testbench top for dispense_trigger_spacing_top: programs the registers over
// APB, drives segment words in bursts and stalls the result channel.
// Depends on dts_pkg, dts_intf, the block's RTL and dts_plan_checker.
`timescale 1ns / 100ps
module dispense_trigger_spacing_top_test import dts_pkg::*;;

  localparam int unsigned TRIGGER_CAP     = 65535;
  localparam int unsigned RANDOM_PHASES   = 16;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  // Allow for a full plan and for long receiver stalls on top.
  localparam int unsigned IDLE_LIMIT      = 5000;
  localparam int unsigned SETTLE_CYCLES   = 200;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int unsigned       pending;
  int unsigned       mismatches;
  int unsigned       idle_cycles = 0;
  int unsigned       burst_left  = 0;

  dts_seg_if seg_if ();
  dts_res_if res_if ();

  dispense_trigger_spacing_top #(
    .MAX_TRIGGERS(TRIGGER_CAP)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // The checker snoops both channels and the register port; it owns all
  // prediction and hands back the count of words still due and of mismatches.
  dts_plan_checker #(
    .MAX_TRIGGERS(TRIGGER_CAP)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_i       (seg_if),
    .res_i       (res_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: count cycles in which no word and no register transfer moves.
  always @(posedge clk_i) begin
    if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Result side: switch between stall patterns, from never stalling to
  // stalling most cycles, each held for a random stretch.
  initial begin : result_stall
    int unsigned stall_pct;
    int unsigned run;
    res_if.ready <= 1'b0;
    forever begin
      case ($urandom_range(3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      run = $urandom_range(16, 256);
      repeat (run) begin
        @(posedge clk_i);
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Spread micrometre values over zero, one, the maximum and three magnitudes.
  function automatic logic [UM_W-1:0] rand_um();
    case ($urandom_range(9))
      0:       return '0;
      1:       return UM_W'(1);
      2:       return '1;
      3, 4, 5: return UM_W'($urandom_range(1, 5000));
      6, 7:    return UM_W'($urandom_range(1, 200000));
      default: return UM_W'($urandom());
    endcase
  endfunction

  function automatic logic [MS_W-1:0] rand_ms();
    case ($urandom_range(7))
      0:       return '0;
      1:       return MS_W'(1);
      2:       return '1;
      3, 4:    return MS_W'($urandom_range(1, 50));
      5, 6:    return MS_W'($urandom_range(1, 2000));
      default: return MS_W'($urandom());
    endcase
  endfunction

  // One APB transfer: setup, access, then drop psel for a cycle so the next
  // transfer raises it in a fresh step.
  task automatic apb_transfer(input logic write, input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Let the checker's count update first so that it includes the last word taken.
  task automatic settle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Change registers only once every result word has come back, then read
  // them all back.
  task automatic apply_setting(input cfg_t s);
    settle();
    apb_transfer(1'b1, REG_SPATIAL,   DATA_W'(s.spatial_um));
    apb_transfer(1'b1, REG_TIME,      DATA_W'(s.time_ms));
    apb_transfer(1'b1, REG_PULSE,     DATA_W'(s.pulse_ms));
    apb_transfer(1'b1, REG_RESPONSE,  DATA_W'(s.response_ms));
    apb_transfer(1'b1, REG_MARGIN,    DATA_W'(s.extra_ms));
    apb_transfer(1'b1, REG_FLOOR,     DATA_W'(s.floor_ms));
    apb_transfer(1'b1, REG_DOWNGRADE, DATA_W'(s.downgrade_en));
    for (int i = int'(REG_SPATIAL); i <= int'(REG_DOWNGRADE); i++)
      apb_transfer(1'b0, IDX_W'(i), '0);
  endtask

  // Offer one segment word and hold it until taken. Keep valid high within a
  // burst; at the end of a burst drop it for a random gap, or not at all.
  // The last word of a sequence always drops valid in the step it is taken.
  task automatic send_segment(input logic [UM_W-1:0] length_um,
                              input logic [UM_W-1:0] speed_um, input bit last);
    int unsigned gap;
    seg_if.valid             <= 1'b1;
    seg_if.segment_length_um <= length_um;
    seg_if.speed_um_per_s    <= speed_um;
    do @(posedge clk_i); while (!seg_if.ready);
    if (last) begin
      seg_if.valid <= 1'b0;
      @(posedge clk_i);
    end else if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        seg_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    cfg_t setting;
    rst_ni                   <= 1'b0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    seg_if.valid             <= 1'b0;
    seg_if.segment_length_um <= '0;
    seg_if.speed_um_per_s    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: skip on zero length or speed, then plan with no spacing
    // source at all, so the residual passes straight through.
    send_segment('0, UM_W'(5), 1'b1);
    send_segment(UM_W'(5), '0, 1'b1);
    send_segment('0, '0, 1'b1);
    send_segment(UM_W'(1000), UM_W'(1000), 1'b1);
    send_segment('1, '1, 1'b1);

    // Spacing of one micrometre: the trigger count saturates.
    setting              = '0;
    setting.downgrade_en = 1'b1;
    setting.spatial_um   = UM_W'(1);
    apply_setting(setting);
    send_segment('1, UM_W'(1), 1'b1);
    send_segment(UM_W'(1), '1, 1'b1);

    // Build a residual, then place the first trigger beyond a short segment.
    setting.spatial_um = UM_W'(1000);
    apply_setting(setting);
    send_segment(UM_W'(3500), UM_W'(500), 1'b1);
    send_segment(UM_W'(200), UM_W'(100), 1'b1);

    // Shrink the spacing below the carried residual so it wraps.
    setting.spatial_um = UM_W'(300);
    apply_setting(setting);
    send_segment(UM_W'(1000), UM_W'(1000), 1'b1);

    // Spacing from the longest time interval, saturating at full speed.
    setting.spatial_um  = '0;
    setting.time_ms     = '1;
    setting.pulse_ms    = MS_W'(10);
    setting.response_ms = MS_W'(20);
    setting.extra_ms    = MS_W'(30);
    apply_setting(setting);
    send_segment('1, '1, 1'b1);
    send_segment(UM_W'(500), UM_W'(1), 1'b1);

    // Safety minimum above the period field's range: downgrade and saturate.
    setting.time_ms     = MS_W'(5);
    setting.pulse_ms    = '1;
    setting.response_ms = '1;
    setting.extra_ms    = '1;
    apply_setting(setting);
    send_segment('1, '1, 1'b1);
    send_segment(UM_W'(1000), UM_W'(3), 1'b1);

    // Same minimum with downgrade off: a safety violation.
    setting.downgrade_en = 1'b0;
    apply_setting(setting);
    send_segment(UM_W'(1000), UM_W'(1000), 1'b1);

    // Period derived from the spacing, against the highest floor.
    setting              = '0;
    setting.downgrade_en = 1'b1;
    setting.spatial_um   = UM_W'(5000);
    setting.floor_ms     = '1;
    apply_setting(setting);
    send_segment(UM_W'(20000), UM_W'(1), 1'b1);
    send_segment(UM_W'(20000), UM_W'(2000000), 1'b1);

    // Widest spacing, shortest period, downgrade off but nothing to violate.
    setting              = '0;
    setting.spatial_um   = '1;
    setting.time_ms      = MS_W'(1);
    apply_setting(setting);
    send_segment(UM_W'(24'hFF_FFFE), UM_W'(7), 1'b1);

    // Random phases: a fresh register setting, then a run of segments.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      setting.spatial_um   = $urandom_range(1) ? rand_um() : '0;
      setting.time_ms      = rand_ms();
      setting.pulse_ms     = ($urandom_range(3) == 0) ? rand_ms() : MS_W'($urandom_range(5));
      setting.response_ms  = ($urandom_range(3) == 0) ? rand_ms() : MS_W'($urandom_range(5));
      setting.extra_ms     = ($urandom_range(3) == 0) ? rand_ms() : MS_W'($urandom_range(5));
      setting.floor_ms     = ($urandom_range(2) == 0) ? rand_ms() : '0;
      setting.downgrade_en = ($urandom_range(3) != 0);
      apply_setting(setting);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_segment(rand_um(), rand_um(), i == ITEMS_PER_PHASE - 1);
    end

    // Drain, then hold a while longer to catch any stray result word.
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== dispense_trigger_spacing_top.f =====
src/dts_pkg.sv
src/dts_intf.sv
src/dts_cfg.sv
src/dts_mul.sv
src/dts_div.sv
src/dispense_trigger_spacing_top.sv
bench/dts_plan_checker.sv
bench/dispense_trigger_spacing_top_test.sv
